// ===== design/pairwise_rank_vote_table_top_assert.svh =====
// Assertion macros used by the pairwise rank vote table RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef PAIRWISE_RANK_VOTE_TABLE_TOP_ASSERT_SVH
`define PAIRWISE_RANK_VOTE_TABLE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PRVT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PRVT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PRVT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define PRVT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/prvt_pkg.sv =====
// Package for the pairwise rank vote table: field widths, request codes,
// controller states and the command/status structs. No dependencies.
package prvt_pkg;

  localparam int MAC_W         = 48;
  localparam int LEVEL_W       = 8;
  localparam int ENTRY_INDEX_W = 5;
  localparam int CELL_VALUE_W  = 16;
  localparam int ENTRY_COUNT_W = 6;

  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_READ_WAIT,
    S_LOOKUP,
    S_COMMIT,
    S_SW_INIT,
    S_SW_RD_ROW,
    S_SW_LAT_ROW,
    S_SW_RD_CELL,
    S_SW_WR_CELL,
    S_SW_END,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic idle;
    logic clr_wr;
    logic rd_issue;
    logic rd_done;
    logic lookup;
    logic commit;
    logic sw_start;
    logic sw_rd_row;
    logic sw_lat_row;
    logic sw_rd_cell;
    logic sw_wr_cell;
    logic sw_end;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_is_read;
    logic lat_last;
    logic clr_last;
    logic sw_none;
    logic cell_last;
    logic row_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/prvt_ctrl.sv =====
// Controller state machine of the pairwise rank vote table.
// Depends on prvt_pkg; drives the datapath by commands, reads its status.
module prvt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  prvt_pkg::dp_stat_t  stat,
  output prvt_pkg::ctl_cmd_t  cmd
);
  import prvt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:      if (stat.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (stat.in_valid) begin
          state_next = stat.in_is_read ? S_READ : S_LOOKUP;
        end
      end
      S_READ:       state_next = S_READ_WAIT;
      S_READ_WAIT:  state_next = S_FINISH;
      S_LOOKUP:     state_next = S_COMMIT;
      S_COMMIT:     state_next = stat.lat_last ? S_SW_INIT : S_FINISH;
      S_SW_INIT:    state_next = stat.sw_none ? S_SW_END : S_SW_RD_ROW;
      S_SW_RD_ROW:  state_next = S_SW_LAT_ROW;
      S_SW_LAT_ROW: state_next = S_SW_RD_CELL;
      S_SW_RD_CELL: state_next = S_SW_WR_CELL;
      S_SW_WR_CELL: begin
        if (!stat.cell_last) begin
          state_next = S_SW_RD_CELL;
        end else if (!stat.row_last) begin
          state_next = S_SW_RD_ROW;
        end else begin
          state_next = S_SW_END;
        end
      end
      S_SW_END:     state_next = S_FINISH;
      S_FINISH:     if (stat.out_free) state_next = S_IDLE;
      default:      state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR:      cmd.clr_wr = 1'b1;
      S_IDLE:       cmd.idle = 1'b1;
      S_READ:       cmd.rd_issue = 1'b1;
      S_READ_WAIT:  cmd.rd_done = 1'b1;
      S_LOOKUP:     cmd.lookup = 1'b1;
      S_COMMIT:     cmd.commit = 1'b1;
      S_SW_INIT:    cmd.sw_start = 1'b1;
      S_SW_RD_ROW:  cmd.sw_rd_row = 1'b1;
      S_SW_LAT_ROW: cmd.sw_lat_row = 1'b1;
      S_SW_RD_CELL: cmd.sw_rd_cell = 1'b1;
      S_SW_WR_CELL: cmd.sw_wr_cell = 1'b1;
      S_SW_END:     cmd.sw_end = 1'b1;
      S_FINISH:     cmd.out_load = stat.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

// ===== design/prvt_dp.sv =====
// Datapath of the pairwise rank vote table: MAC table, levels, vote memory,
// sweep counters and result register. Depends on prvt_pkg and the assert header.
`include "pairwise_rank_vote_table_top_assert.svh"
module prvt_dp #(
  parameter int MAX_ENTRIES  = 32,
  parameter int COUNTER_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  input  logic                                       req_type,
  input  logic [prvt_pkg::MAC_W-1:0]                 ap_mac,
  input  logic signed [prvt_pkg::LEVEL_W-1:0]        signal_level,
  input  logic                                       last_of_scan,
  input  logic [prvt_pkg::ENTRY_INDEX_W-1:0]         read_row,
  input  logic [prvt_pkg::ENTRY_INDEX_W-1:0]         read_col,
  input  prvt_pkg::ctl_cmd_t                         cmd,
  output prvt_pkg::dp_stat_t                         stat,
  input  logic                                       out_ready,
  output logic                                       out_valid,
  output logic [prvt_pkg::ENTRY_INDEX_W-1:0]         entry_index,
  output logic                                       is_new_entry,
  output logic                                       table_full,
  output logic                                       scan_done,
  output logic signed [prvt_pkg::CELL_VALUE_W-1:0]   cell_value,
  output logic [prvt_pkg::MAC_W-1:0]                 cell_mac,
  output logic [prvt_pkg::ENTRY_COUNT_W-1:0]         entry_count
);
  import prvt_pkg::*;

  localparam int IW    = $clog2(MAX_ENTRIES);
  localparam int UW    = $clog2(MAX_ENTRIES + 1);
  localparam int NCELL = MAX_ENTRIES * MAX_ENTRIES;
  localparam int AW    = $clog2(NCELL);
  localparam int IXW   = ((IW > ENTRY_INDEX_W) ? IW : ENTRY_INDEX_W) + 1;
  localparam logic signed [COUNTER_BITS-1:0] CMAX = {1'b0, {(COUNTER_BITS-1){1'b1}}};
  localparam logic signed [COUNTER_BITS-1:0] CMIN = {1'b1, {(COUNTER_BITS-1){1'b0}}};

  logic                      accept;
  logic                      lat_req;
  logic [MAC_W-1:0]          lat_mac;
  logic signed [LEVEL_W-1:0] lat_level;
  logic                      lat_last;
  logic [ENTRY_INDEX_W-1:0]  lat_row;
  logic [ENTRY_INDEX_W-1:0]  lat_col;

  logic [MAC_W-1:0]          mac_table [MAX_ENTRIES];
  logic [UW-1:0]             used;
  logic [MAX_ENTRIES-1:0]    present;
  logic [MAX_ENTRIES-1:0]    hit;

  logic [IW-1:0]             r_idx;
  logic [IW-1:0]             c_idx;
  logic signed [LEVEL_W-1:0] level_r;
  logic [AW-1:0]             clr_addr;

  logic signed [LEVEL_W-1:0]      lvl_mem [MAX_ENTRIES];
  logic signed [LEVEL_W-1:0]      lvl_q;
  logic [IW-1:0]                  lvl_raddr;
  logic signed [COUNTER_BITS-1:0] mat_mem [NCELL];
  logic signed [COUNTER_BITS-1:0] mat_q;
  logic [AW-1:0]                  mat_raddr;
  logic [AW-1:0]                  mat_waddr;
  logic signed [COUNTER_BITS-1:0] mat_wdata;
  logic                           mat_wen;

  logic [ENTRY_INDEX_W-1:0]        res_index;
  logic                            res_new;
  logic                            res_full;
  logic                            res_done;
  logic signed [CELL_VALUE_W-1:0]  res_cell;
  logic [MAC_W-1:0]                res_cmac;

  logic                           found;
  logic [IW-1:0]                  hit_idx;
  logic                           room;
  logic                           take;
  logic                           append;
  logic [IW-1:0]                  slot;
  logic [IXW-1:0]                 row_x;
  logic [IXW-1:0]                 col_x;
  logic                           in_range;
  logic [IW-1:0]                  row_idx;
  logic [IW-1:0]                  col_idx;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  sweep_addr;
  logic                           gt;
  logic                           lt;
  logic                           change;
  logic                           pair_present;
  logic signed [COUNTER_BITS-1:0] new_val;
  logic signed [31:0]             mat_ext;

  assign accept = cmd.idle && in_valid;

  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (hit[k]) hit_idx = hit_idx | IW'(k);
    end
  end

  assign found    = |hit;
  assign room     = used < UW'(MAX_ENTRIES);
  assign take     = found || room;
  assign append   = !found && room;
  assign slot     = found ? hit_idx : IW'(used);
  assign row_x    = IXW'(lat_row);
  assign col_x    = IXW'(lat_col);
  assign in_range = (row_x < IXW'(MAX_ENTRIES)) && (col_x < IXW'(MAX_ENTRIES));
  assign row_idx  = row_x[IW-1:0];
  assign col_idx  = col_x[IW-1:0];
  assign rd_addr    = AW'(int'(row_idx) * MAX_ENTRIES + int'(col_idx));
  assign sweep_addr = AW'(int'(r_idx) * MAX_ENTRIES + int'(c_idx));
  assign lvl_raddr  = cmd.sw_rd_row ? r_idx : c_idx;
  assign mat_raddr  = cmd.rd_issue ? rd_addr : sweep_addr;

  assign gt           = level_r > lvl_q;
  assign lt           = level_r < lvl_q;
  assign pair_present = present[r_idx] && present[c_idx];
  assign change       = (gt && (mat_q != CMAX)) || (lt && (mat_q != CMIN));
  assign new_val      = gt ? mat_q + COUNTER_BITS'(1) : mat_q - COUNTER_BITS'(1);
  assign mat_ext      = 32'(mat_q);

  assign mat_wen   = cmd.clr_wr || (cmd.sw_wr_cell && pair_present && change);
  assign mat_waddr = cmd.clr_wr ? clr_addr : sweep_addr;
  assign mat_wdata = cmd.clr_wr ? '0 : new_val;

  always_comb begin
    stat            = '0;
    stat.in_valid   = in_valid;
    stat.in_is_read = req_type == REQ_READ;
    stat.lat_last   = lat_last;
    stat.clr_last   = clr_addr == AW'(NCELL - 1);
    stat.sw_none    = used <= UW'(1);
    stat.cell_last  = IW'(c_idx + 1'b1) == r_idx;
    stat.row_last   = ((UW+1)'(r_idx) + 1'b1) >= (UW+1)'(used);
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (mat_wen) begin
      mat_mem[mat_waddr] <= mat_wdata;
    end
    mat_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && take) begin
      lvl_mem[slot] <= lat_level;
    end
    lvl_q <= lvl_mem[lvl_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lat_req   <= req_type;
      lat_mac   <= ap_mac;
      lat_level <= signal_level;
      lat_last  <= last_of_scan;
      lat_row   <= read_row;
      lat_col   <= read_col;
    end
    if (cmd.lookup) begin
      for (int k = 0; k < MAX_ENTRIES; k++) begin
        hit[k] <= (UW'(k) < used) && (mac_table[k] == lat_mac);
      end
    end
    if (cmd.commit && append) begin
      mac_table[slot] <= lat_mac;
    end
    if (cmd.sw_lat_row) begin
      level_r <= lvl_q;
    end
    if (cmd.sw_start) begin
      r_idx <= IW'(1);
      c_idx <= '0;
    end else if (cmd.sw_wr_cell) begin
      if (IW'(c_idx + 1'b1) == r_idx) begin
        r_idx <= r_idx + 1'b1;
        c_idx <= '0;
      end else begin
        c_idx <= c_idx + 1'b1;
      end
    end
    if (cmd.commit) begin
      res_index <= take ? ENTRY_INDEX_W'(slot) : '0;
      res_new   <= append;
      res_full  <= !take;
      res_done  <= 1'b0;
      res_cell  <= '0;
      res_cmac  <= '0;
    end else if (cmd.sw_end) begin
      res_done <= 1'b1;
    end else if (cmd.rd_done) begin
      res_index <= lat_row;
      res_new   <= 1'b0;
      res_full  <= 1'b0;
      res_done  <= 1'b0;
      res_cell  <= in_range ? mat_ext[CELL_VALUE_W-1:0] : '0;
      res_cmac  <= (in_range && (row_x < IXW'(used))) ? mac_table[row_idx] : '0;
    end
    if (cmd.out_load) begin
      entry_index  <= res_index;
      is_new_entry <= res_new && (lat_req == REQ_SCAN);
      table_full   <= res_full;
      scan_done    <= res_done;
      cell_value   <= res_cell;
      cell_mac     <= res_cmac;
      entry_count  <= ENTRY_COUNT_W'(used);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      present   <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.commit && append) begin
        used <= used + 1'b1;
      end
      if (cmd.commit && take) begin
        present[slot] <= 1'b1;
      end else if (cmd.sw_end) begin
        present <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PRVT_ASSERT_IMPL(a_used_bound, clk, rst, 1'b1, used <= UW'(MAX_ENTRIES), "entry count above table size")
  `PRVT_ASSERT_NEXT(a_append_count, clk, rst, cmd.commit && append, used == $past(used) + 1'b1, "append did not grow the table")
  `PRVT_ASSERT_NEXT(a_sweep_clears, clk, rst, cmd.sw_end, present == '0, "present marks survive the sweep")
  `PRVT_ASSERT_IMPL(a_sweep_lower, clk, rst, cmd.sw_wr_cell, c_idx < r_idx, "sweep touched a cell on or above the diagonal")

endmodule

// ===== design/pairwise_rank_vote_table_top.sv =====
// Pairwise rank vote table. Input channel takes one transaction per scan
// sample or cell read; output channel returns exactly one result per input.
// Scan samples: a sample's MAC is matched against the table, appended or
// dropped (table_full); a kept sample's level is recorded. A sample with
// last_of_scan runs the vote sweep over all present pairs before its
// result appears. A scan sample passes through the lookup and commit
// states, a read through the read and read-wait states; both then load
// the result into the output register in the finish state. A closing
// sample first sweeps the vote memory: for each row it reads and latches
// the row's level, then reads and writes each of the row's counters in
// turn; the vote memory has one read port and one write port.
// Flow: one transaction at a time; a new input is taken as soon as the
// previous result sits in the output register, even while it stalls.
// If the receiver holds out_ready low, the result waits in the output
// register and the block stops before loading the next one.
// Reset: synchronous; afterwards the vote memory is cleared one counter a
// cycle (MAX_ENTRIES*MAX_ENTRIES counters, 1024 by default) with in_ready low.
// Depends on prvt_pkg, prvt_ctrl and prvt_dp.
module pairwise_rank_vote_table_top #(
  parameter int MAX_ENTRIES  = 32,
  parameter int COUNTER_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic                                       req_type,
  input  logic [prvt_pkg::MAC_W-1:0]                 ap_mac,
  input  logic signed [prvt_pkg::LEVEL_W-1:0]        signal_level,
  input  logic                                       last_of_scan,
  input  logic [prvt_pkg::ENTRY_INDEX_W-1:0]         read_row,
  input  logic [prvt_pkg::ENTRY_INDEX_W-1:0]         read_col,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [prvt_pkg::ENTRY_INDEX_W-1:0]         entry_index,
  output logic                                       is_new_entry,
  output logic                                       table_full,
  output logic                                       scan_done,
  output logic signed [prvt_pkg::CELL_VALUE_W-1:0]   cell_value,
  output logic [prvt_pkg::MAC_W-1:0]                 cell_mac,
  output logic [prvt_pkg::ENTRY_COUNT_W-1:0]         entry_count
);
  import prvt_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign in_ready = cmd.idle;

  prvt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  prvt_dp #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .req_type     (req_type),
    .ap_mac       (ap_mac),
    .signal_level (signal_level),
    .last_of_scan (last_of_scan),
    .read_row     (read_row),
    .read_col     (read_col),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .entry_index  (entry_index),
    .is_new_entry (is_new_entry),
    .table_full   (table_full),
    .scan_done    (scan_done),
    .cell_value   (cell_value),
    .cell_mac     (cell_mac),
    .entry_count  (entry_count)
  );

endmodule
